@@ rtl/kmd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared constants and types for the key matrix debounce event block.
// ----------------------------------------------------------------------------
package kmd_pkg;

  localparam int NUM_KEYS    = 8;
  localparam int KEY_W       = 8;
  localparam int ACTIVE_KEYS = (NUM_KEYS > KEY_W) ? KEY_W : NUM_KEYS;
  localparam int IDX_W       = $clog2(KEY_W);
  localparam int TIME_W      = 32;
  localparam int GAP_W       = 8;

  localparam logic [KEY_W-1:0] USED_MASK =
    (ACTIVE_KEYS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << ACTIVE_KEYS) - 1);
  localparam logic [KEY_W-1:0] UNUSED_MASK = ~USED_MASK;
  localparam logic [KEY_W-1:0] STABLE_RESET = {KEY_W{1'b1}};
  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(5);

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  localparam int EVQ_DEPTH = 2;
  localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
  localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

  typedef struct packed {
    logic [KEY_W-1:0] changed;
    logic [KEY_W-1:0] level;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0] key_index;
    logic             key_pressed;
    logic             last_event;
  } event_t;

  typedef struct packed {
    logic valid;
    logic full;
  } jobq_status_t;

endpackage
`default_nettype wire

@@ rtl/kmd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_front
// Sample timing, first and confirming reads, stable set, and job creation.
// ----------------------------------------------------------------------------
module kmd_front
  import kmd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [GAP_W-1:0]   cfg_wr_data,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [TIME_W-1:0]  in_now_ms,
  input  wire logic [KEY_W-1:0]   in_raw_keys,
  input  wire logic               jq_full,
  output logic                    job_push,
  output job_t                    job
);

  logic [GAP_W-1:0]  sample_gap_ms_r;
  logic [TIME_W-1:0] last_sample_time_r;
  logic              awaiting_confirm_r;
  logic [KEY_W-1:0]  first_sample_r;
  logic [KEY_W-1:0]  stable_keys_r;

  logic [TIME_W-1:0] elapsed;
  logic [KEY_W-1:0]  sample;
  logic              accept;
  logic              take;
  logic              confirm_ok;

  assign in_full    = jq_full;
  assign accept     = in_push && !in_full;
  assign elapsed    = in_now_ms - last_sample_time_r;
  assign take       = accept && (elapsed > TIME_W'(sample_gap_ms_r));
  assign sample     = in_raw_keys | UNUSED_MASK;
  assign confirm_ok = awaiting_confirm_r && (sample == first_sample_r)
                      && (first_sample_r != stable_keys_r);

  assign job_push    = take && confirm_ok;
  assign job.changed = first_sample_r ^ stable_keys_r;
  assign job.level   = first_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_gap_ms_r    <= GAP_RESET;
      last_sample_time_r <= '0;
      awaiting_confirm_r <= 1'b0;
      first_sample_r     <= '0;
      stable_keys_r      <= STABLE_RESET;
    end else begin
      if (cfg_wr_en) begin
        sample_gap_ms_r <= cfg_wr_data;
      end
      if (take) begin
        last_sample_time_r <= in_now_ms;
        if (!awaiting_confirm_r) begin
          awaiting_confirm_r <= 1'b1;
          first_sample_r     <= sample;
        end else begin
          awaiting_confirm_r <= 1'b0;
          if (confirm_ok) begin
            stable_keys_r <= first_sample_r;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/kmd_job_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_job_queue
// Short queue of change jobs between the sampling front and the event back.
// ----------------------------------------------------------------------------
module kmd_job_queue
  import kmd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire job_t   push_job,
  input  wire logic   pop,
  output jobq_status_t status,
  output job_t        head
);

  job_t                  mem [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr_r;
  logic [JOBQ_PTR_W-1:0] rd_ptr_r;
  logic [JOBQ_CNT_W-1:0] count_r;
  logic                  do_push;
  logic                  do_pop;

  assign status.valid = (count_r != '0);
  assign status.full  = (count_r == JOBQ_CNT_W'(JOBQ_DEPTH));
  assign head         = mem[rd_ptr_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/kmd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_back
// Walks the changed keys of a job in key order and queues one event per key.
// ----------------------------------------------------------------------------
module kmd_back
  import kmd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          jq_valid,
  input  wire job_t          jq_head,
  output logic               jq_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [IDX_W-1:0]   out_key_index,
  output logic               out_key_pressed,
  output logic               out_last_event
);

  logic [KEY_W-1:0]     mask_r;
  logic [KEY_W-1:0]     mask_nxt;
  logic [KEY_W-1:0]     level_r;
  logic [KEY_W-1:0]     low_bit;
  logic [IDX_W-1:0]     low_idx;
  logic [KEY_W-1:0]     mask_after;
  logic                 emit;
  event_t               ev;

  event_t               evq [EVQ_DEPTH];
  logic [EVQ_PTR_W-1:0] ev_wr_ptr_r;
  logic [EVQ_PTR_W-1:0] ev_rd_ptr_r;
  logic [EVQ_CNT_W-1:0] ev_count_r;
  logic                 ev_space;
  logic                 ev_pop;
  event_t               ev_head;

  always_comb begin
    low_idx = '0;
    for (int i = KEY_W - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign low_bit    = mask_r & (~mask_r + 1'b1);
  assign ev_space   = (ev_count_r != EVQ_CNT_W'(EVQ_DEPTH));
  assign emit       = (mask_r != '0) && ev_space;
  assign mask_after = emit ? (mask_r & ~low_bit) : mask_r;
  assign jq_pop     = (mask_after == '0) && jq_valid;
  assign mask_nxt   = jq_pop ? jq_head.changed : mask_after;

  assign ev.key_index   = low_idx;
  assign ev.key_pressed = ~level_r[low_idx];
  assign ev.last_event  = ((mask_r & ~low_bit) == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (jq_pop) begin
      level_r <= jq_head.level;
    end
  end

  assign ev_pop          = out_pop && !out_empty;
  assign out_empty       = (ev_count_r == '0);
  assign ev_head         = evq[ev_rd_ptr_r];
  assign out_key_index   = ev_head.key_index;
  assign out_key_pressed = ev_head.key_pressed;
  assign out_last_event  = ev_head.last_event;

  always_ff @(posedge clk) begin
    if (emit) begin
      evq[ev_wr_ptr_r] <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_wr_ptr_r <= '0;
      ev_rd_ptr_r <= '0;
      ev_count_r  <= '0;
    end else begin
      if (emit) begin
        ev_wr_ptr_r <= (ev_wr_ptr_r == EVQ_PTR_W'(EVQ_DEPTH - 1)) ? '0 : ev_wr_ptr_r + 1'b1;
      end
      if (ev_pop) begin
        ev_rd_ptr_r <= (ev_rd_ptr_r == EVQ_PTR_W'(EVQ_DEPTH - 1)) ? '0 : ev_rd_ptr_r + 1'b1;
      end
      if (emit && !ev_pop) begin
        ev_count_r <= ev_count_r + 1'b1;
      end else if (ev_pop && !emit) begin
        ev_count_r <= ev_count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/key_matrix_debounce_events_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// key_matrix_debounce_events_core
// Debounced press and release events for a 2x4 key matrix.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  input     in_push / in_full  in_now_ms, in_raw_keys
//  result    out_pop / out_empty out_key_index, out_key_pressed, out_last_event
//  config    cfg_wr_en          cfg_wr_data (sample gap in ms)
//
// The front takes one input per cycle while the job queue has room.
// The back issues one event per cycle while the event queue has room, so an
// input that changes k keys yields k events; the walk sets the sustained rate.
// Reset is synchronous; the first cycle after reset already accepts input.
// A stalled result side fills the event and job queues, then raises in_full.
// ----------------------------------------------------------------------------
module key_matrix_debounce_events_core
  import kmd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [GAP_W-1:0]   cfg_wr_data,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [TIME_W-1:0]  in_now_ms,
  input  wire logic [KEY_W-1:0]   in_raw_keys,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [IDX_W-1:0]        out_key_index,
  output logic                    out_key_pressed,
  output logic                    out_last_event
);

  jobq_status_t jq_status;
  logic         job_push;
  job_t         job;
  job_t         jq_head;
  logic         jq_pop;

  kmd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_now_ms   (in_now_ms),
    .in_raw_keys (in_raw_keys),
    .jq_full     (jq_status.full),
    .job_push    (job_push),
    .job         (job)
  );

  kmd_job_queue u_job_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (jq_pop),
    .status   (jq_status),
    .head     (jq_head)
  );

  kmd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .jq_valid        (jq_status.valid),
    .jq_head         (jq_head),
    .jq_pop          (jq_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_key_index   (out_key_index),
    .out_key_pressed (out_key_pressed),
    .out_last_event  (out_last_event)
  );

endmodule
`default_nettype wire
